@@ design/fir1d_pkg.sv @@
// Shared widths, constants and sideband type for the 1-D FIR convolution block.
package fir1d_pkg;

    localparam int SAMPLE_W  = 16;                    // sample width
    localparam int COEF_W    = 16;                    // Q1.15 coefficient width
    localparam int PROD_W    = SAMPLE_W + COEF_W;     // full 16x16 product
    localparam int NUM_COEF  = 8;                     // coefficient registers / cells
    localparam int CFG_IDX_W = $clog2(NUM_COEF);      // register index width
    localparam int SUM2_W    = PROD_W + 1;            // first tree level
    localparam int SUM3_W    = PROD_W + 2;            // second tree level
    localparam int OUT_W     = PROD_W + 3;            // full-precision result
    localparam int TAPS_DEF  = 8;                     // default kernel length

    // Control bits that travel with a word through the pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } t_side;

endpackage

@@ design/fir1d_cell.sv @@
// One tap cell: holds a window sample, passes it to its older neighbor, registers its product.
module fir1d_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                                     i_clk,
    input  logic                                     i_shift,
    input  logic                                     i_load,
    input  logic signed [fir1d_pkg::COEF_W-1:0]      i_coef,
    input  logic signed [fir1d_pkg::SAMPLE_W-1:0]    i_x_next,
    output logic signed [fir1d_pkg::SAMPLE_W-1:0]    o_x,
    output logic signed [fir1d_pkg::PROD_W-1:0]      o_prod
);

    logic signed [fir1d_pkg::SAMPLE_W-1:0] w_tap;
    logic signed [fir1d_pkg::PROD_W-1:0]   w_prod;
    logic signed [fir1d_pkg::PROD_W-1:0]   r_prod;

    generate
        if (IS_HEAD) begin : g_head
            // newest tap: multiplies the arriving sample directly
            assign w_tap = i_x_next;
        end else begin : g_tap
            logic signed [fir1d_pkg::SAMPLE_W-1:0] r_x;
            always_ff @(posedge i_clk) begin
                if (i_shift) begin
                    r_x <= i_x_next;
                end
            end
            assign w_tap = r_x;
        end
    endgenerate

    assign w_prod = i_coef * w_tap;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_prod;
        end
    end

    assign o_x    = w_tap;
    assign o_prod = r_prod;

endmodule

@@ design/fir1d_sum.sv @@
// Registered three-level adder tree over the cell products.
module fir1d_sum (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic signed [fir1d_pkg::PROD_W-1:0]    i_prod [fir1d_pkg::NUM_COEF],
    input  fir1d_pkg::t_side                       i_side,
    output logic signed [fir1d_pkg::OUT_W-1:0]     o_sum,
    output fir1d_pkg::t_side                       o_side
);

    localparam int L2 = fir1d_pkg::NUM_COEF / 2;
    localparam int L3 = fir1d_pkg::NUM_COEF / 4;

    logic signed [fir1d_pkg::SUM2_W-1:0] r_s2 [L2];
    logic signed [fir1d_pkg::SUM3_W-1:0] r_s3 [L3];
    logic signed [fir1d_pkg::OUT_W-1:0]  r_s4;
    fir1d_pkg::t_side                    r_side2, r_side3, r_side4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < L2; j++) begin
                r_s2[j] <= fir1d_pkg::SUM2_W'(i_prod[2*j])
                         + fir1d_pkg::SUM2_W'(i_prod[2*j+1]);
            end
            for (int j = 0; j < L3; j++) begin
                r_s3[j] <= fir1d_pkg::SUM3_W'(r_s2[2*j]) + fir1d_pkg::SUM3_W'(r_s2[2*j+1]);
            end
            r_s4 <= fir1d_pkg::OUT_W'(r_s3[0]) + fir1d_pkg::OUT_W'(r_s3[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side2 <= '0;
            r_side3 <= '0;
            r_side4 <= '0;
        end else if (i_en) begin
            r_side2 <= i_side;
            r_side3 <= r_side2;
            r_side4 <= r_side3;
        end
    end

    assign o_sum  = r_s4;
    assign o_side = r_side4;

endmodule

@@ design/fir_convolution_1d_top.sv @@
// Top level of the streaming 1-D FIR convolution (direct form, correlation order).
//
// Streaming FIR filter: accepts one 16-bit signed sample word per clock when
// not stalled and, once TAPS samples of the current line are in, returns one
// 35-bit full-precision sum of coef_k * x_k per sample (coef_0 weights the
// oldest sample, coef_(TAPS-1) the sample just accepted; never saturated;
// read as Q1.15 it is the result times 2^15). The first TAPS-1 samples
// of every line give no output word, and a line shorter than TAPS gives none
// at all; end_of_line restarts window filling. Throughput is one word per
// clock while o_stall is low: a chain of TAPS tap cells, each with one 16x16
// multiplier, shifts the window on every accepted word, and a registered
// adder tree follows. The product register loads at the accept edge, then
// three tree levels follow. The whole pipeline moves as one; it holds only
// while the output word is valid and stalled, so o_stall follows i_stall
// combinationally. Coefficients are written through the cfg port (index 0..7)
// and must only be changed while no words are in flight.
module fir_convolution_1d_top #(
    parameter int TAPS = fir1d_pkg::TAPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_wr_en,
    input  logic [fir1d_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fir1d_pkg::COEF_W-1:0]            i_cfg_data,
    // sample input
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [fir1d_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                    i_end_of_line,
    // result output
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [fir1d_pkg::OUT_W-1:0]      o_filtered_value,
    output logic                                    o_line_done
);

    localparam int HIST  = TAPS - 1;              // samples held in the window
    localparam int CNT_W = $clog2(TAPS + 1);      // fill counter, holds 0..HIST

    // coefficient registers
    logic signed [fir1d_pkg::COEF_W-1:0] r_coef [fir1d_pkg::NUM_COEF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fir1d_pkg::NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            for (int k = 0; k < fir1d_pkg::NUM_COEF; k++) begin
                if (i_cfg_index == fir1d_pkg::CFG_IDX_W'(k)) begin
                    r_coef[k] <= i_cfg_data;
                end
            end
        end
    end

    // pipeline advance: only an output word that is valid and stalled holds it
    logic w_en;
    logic w_in_acc;
    logic w_fire;

    assign w_en     = !(o_valid && i_stall);
    assign o_stall  = !w_en;
    assign w_in_acc = i_valid && w_en;

    // fill counter: samples of the current line, saturating at HIST
    logic [CNT_W-1:0] r_fill, n_fill;

    assign w_fire = (r_fill >= CNT_W'(HIST));

    always_comb begin
        n_fill = r_fill;
        if (w_in_acc) begin
            if (i_end_of_line) begin
                n_fill = '0;
            end else if (r_fill < CNT_W'(HIST)) begin
                n_fill = r_fill + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // tap cell chain; cell k holds window entry k, cell TAPS-1 takes the new sample
    logic signed [fir1d_pkg::SAMPLE_W-1:0] w_x    [fir1d_pkg::NUM_COEF];
    logic signed [fir1d_pkg::PROD_W-1:0]   w_prod [fir1d_pkg::NUM_COEF];

    generate
        for (genvar k = 0; k < fir1d_pkg::NUM_COEF; k++) begin : g_cell
            if (k < TAPS) begin : g_used
                logic signed [fir1d_pkg::SAMPLE_W-1:0] w_next;
                if (k + 1 < HIST) begin : g_mid
                    assign w_next = w_x[k+1];
                end else begin : g_new
                    assign w_next = i_sample;
                end
                fir1d_cell #(
                    .IS_HEAD (k == TAPS - 1)
                ) u_cell (
                    .i_clk    (i_clk),
                    .i_shift  (w_in_acc),
                    .i_load   (w_en),
                    .i_coef   (r_coef[k]),
                    .i_x_next (w_next),
                    .o_x      (w_x[k]),
                    .o_prod   (w_prod[k])
                );
            end else begin : g_pad
                // kernel positions past TAPS contribute nothing
                assign w_x[k]    = '0;
                assign w_prod[k] = '0;
            end
        end
    endgenerate

    // sideband for the product stage
    fir1d_pkg::t_side r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_en) begin
            r_s1.vld  <= w_in_acc && w_fire;
            r_s1.last <= i_end_of_line;
        end
    end

    fir1d_pkg::t_side w_out_side;

    fir1d_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_prod  (w_prod),
        .i_side  (r_s1),
        .o_sum   (o_filtered_value),
        .o_side  (w_out_side)
    );

    assign o_valid     = w_out_side.vld;
    assign o_line_done = w_out_side.last;

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(HIST))
        else $error("fill counter above window depth");

    a_fire_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_fire |=> r_s1.vld)
        else $error("full window did not launch a word");

    a_fill_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_fire |=> !r_s1.vld)
        else $error("word launched before window filled");

    a_eol_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_end_of_line |=> r_fill == '0)
        else $error("end of line did not restart filling");

endmodule

@@ test/fir_convolution_1d_top_tb.sv @@
// Self-checking testbench for the streaming 1-D FIR convolution top level.
module fir_convolution_1d_top_tb;

    localparam int HIST       = fir1d_pkg::NUM_COEF - 1;   // samples held besides the new one
    localparam int PIPE_SLACK = 8;              // pipeline latency plus margin
    localparam int PHASES     = 12;
    localparam int PHASE_WORDS = 110;

    // How a directed row is checked.
    typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_MODEL} t_check;
    // Handshake pacing per phase.
    typedef enum logic [1:0] {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} t_pace;
    // Kernel shapes used by the random phases.
    typedef enum logic [2:0] {
        KERN_RANDOM, KERN_MAX, KERN_MIN, KERN_IMPULSE, KERN_ALT, KERN_SMALL
    } t_kernel;
    // Coefficient register map.
    typedef enum logic [fir1d_pkg::CFG_IDX_W-1:0] {
        REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3,
        REG_COEF_4, REG_COEF_5, REG_COEF_6, REG_COEF_7
    } t_coef_reg;

    typedef struct packed {
        logic signed [fir1d_pkg::OUT_W-1:0] value;
        logic                               done;
    } t_fir_result;

    typedef struct packed {
        logic                                  min_kernel;  // 1: all coefs at -1.0
        logic signed [fir1d_pkg::SAMPLE_W-1:0] sample;
        logic                                  eol;
        t_check                                chk;
        logic signed [fir1d_pkg::OUT_W-1:0]    value;
        logic                                  done;
    } t_plan_row;

    // Directed rows. Typed results are the easy ones: zero kernel, and the
    // all -1.0 kernel against full-scale windows (both output extremes).
    localparam int PLAN_ROWS = 28;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // reset kernel: one-sample line, then a full line whose sum is zero
        '{1'b0, 16'sh8000, 1'b1, CHK_NONE,  35'sd0, 1'b0},
        '{1'b0, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'sh1234, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'shEDCB, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'sh0000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'shFFFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'sh5555, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b0, 16'shAAAA, 1'b1, CHK_TYPED, 35'sd0, 1'b1},
        // all -1.0 kernel: window of -1.0 gives the positive extreme
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, CHK_TYPED, 35'sd8589934592, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b1, CHK_TYPED, 35'sd6442483712, 1'b1},
        // short line over a stale window: no word at all
        '{1'b1, 16'sh3039, 1'b0, CHK_NONE,  35'sd0, 1'b0},
        '{1'b1, 16'shFFFF, 1'b1, CHK_NONE,  35'sd0, 1'b0},
        // full line of +max gives the negative extreme
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b0, CHK_MODEL, 35'sd0, 1'b0},
        '{1'b1, 16'sh7FFF, 1'b1, CHK_TYPED, -35'sd8589672448, 1'b1}
    };

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  i_cfg_wr_en;
    logic [fir1d_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [fir1d_pkg::COEF_W-1:0]          i_cfg_data;
    logic                                  i_valid;
    logic                                  o_stall;
    logic signed [fir1d_pkg::SAMPLE_W-1:0] i_sample;
    logic                                  i_end_of_line;
    logic                                  o_valid;
    logic                                  i_stall = 1'b0;
    logic signed [fir1d_pkg::OUT_W-1:0]    o_filtered_value;
    logic                                  o_line_done;

    fir_convolution_1d_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_end_of_line    (i_end_of_line),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_filtered_value (o_filtered_value),
        .o_line_done      (o_line_done)
    );

    // Shadow of the filter: kernel, sample history (oldest first), fill level.
    logic signed [fir1d_pkg::COEF_W-1:0]   kernel_q [fir1d_pkg::NUM_COEF];
    logic signed [fir1d_pkg::SAMPLE_W-1:0] history_q [HIST];
    int                                    fill_level = 0;

    t_fir_result pending_sums [$];   // expected words, oldest first
    t_pace       pace = PACE_FULL;
    int          err_count = 0;
    int          words_in = 0;
    int          sums_seen = 0;
    int          lines_sent = 0;
    int          short_lines = 0;
    int          kernels_used = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #(20 * 400_000);
        $display("fir_convolution_1d_top_tb: done, errors");
        $finish;
    end

    // One accepted sample through the shadow filter: correlation of the kernel
    // with the history plus the new sample, then shift and count.
    function automatic void fir_filter_step(
        input logic signed [fir1d_pkg::SAMPLE_W-1:0] s,
        input logic eol,
        output bit fired,
        output t_fir_result sum);
        logic signed [fir1d_pkg::OUT_W-1:0] acc;
        acc   = '0;
        fired = (fill_level >= HIST);
        for (int k = 0; k < HIST; k++)
            acc = acc + kernel_q[k] * history_q[k];
        acc = acc + kernel_q[HIST] * s;
        sum.value = acc;
        sum.done  = eol;
        for (int k = 0; k + 1 < HIST; k++)
            history_q[k] = history_q[k + 1];
        history_q[HIST - 1] = s;
        if (eol)
            fill_level = 0;
        else if (fill_level < HIST)
            fill_level++;
    endfunction

    task automatic note_error(input string what,
                              input logic signed [fir1d_pkg::OUT_W-1:0] want,
                              input logic signed [fir1d_pkg::OUT_W-1:0] got);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Present one word; idle cycles (with junk payload) come first as the
    // pacing mode asks. Valid stays high afterwards so words can go back to back.
    task automatic send_word(input logic signed [fir1d_pkg::SAMPLE_W-1:0] s,
                             input logic eol,
                             input t_check chk, input t_fir_result typed);
        int          gap;
        int          pct;
        bit          fired;
        t_fir_result sum;
        pct = (pace == PACE_SEND_IDLE) ? 63 : (pace == PACE_BOTH) ? 13 : 0;
        gap = 0;
        while ($urandom_range(99) < pct)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid       = 1'b0;
            i_sample      = fir1d_pkg::SAMPLE_W'($urandom);
            i_end_of_line = 1'($urandom_range(1));
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_sample      = s;
        i_end_of_line = eol;
        do @(posedge i_clk); while (o_stall);
        words_in++;
        fir_filter_step(s, eol, fired, sum);
        case (chk)
            CHK_MODEL: if (fired) pending_sums.push_back(sum);
            CHK_TYPED: pending_sums.push_back(typed);
            default: ;
        endcase
    endtask

    // Stop sending and let every expected word and any silent tail drain out.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_sums.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_kernel(
        input logic signed [fir1d_pkg::COEF_W-1:0] k [fir1d_pkg::NUM_COEF]);
        for (int i = 0; i < fir1d_pkg::NUM_COEF; i++) begin
            @(negedge i_clk);
            i_cfg_wr_en = 1'b1;
            i_cfg_index = t_coef_reg'(i);
            i_cfg_data  = k[i];
            kernel_q[i] = k[i];
        end
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        kernels_used++;
    endtask

    // Receiver side: stall at random per pacing mode.
    always @(negedge i_clk) begin
        i_stall = (pace == PACE_RECV_STALL) ? ($urandom_range(99) < 63) :
                  (pace == PACE_BOTH)       ? ($urandom_range(99) < 13) : 1'b0;
    end

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge i_clk) begin : check_out
        t_fir_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            sums_seen++;
            if (pending_sums.size() == 0) begin
                note_error("word with nothing expected", '0, o_filtered_value);
            end else begin
                want = pending_sums.pop_front();
                if (o_filtered_value !== want.value)
                    note_error("filtered_value", want.value, o_filtered_value);
                if (o_line_done !== want.done)
                    note_error("line_done", fir1d_pkg::OUT_W'(want.done),
                               fir1d_pkg::OUT_W'(o_line_done));
            end
        end
    end

    initial begin : stimulus
        logic signed [fir1d_pkg::COEF_W-1:0]   kern [fir1d_pkg::NUM_COEF];
        logic signed [fir1d_pkg::SAMPLE_W-1:0] s;
        logic   min_loaded;
        int     line_left;
        int     pick;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_end_of_line = 1'b0;
        for (int i = 0; i < fir1d_pkg::NUM_COEF; i++)
            kernel_q[i] = '0;
        for (int i = 0; i < HIST; i++)
            history_q[i] = '0;
        min_loaded = 1'b0;
        line_left  = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, full speed on both sides.
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].min_kernel != min_loaded) begin
                wait_idle();
                for (int i = 0; i < fir1d_pkg::NUM_COEF; i++)
                    kern[i] = 16'sh8000;
                write_kernel(kern);
                min_loaded = PLAN[r].min_kernel;
            end
            if (PLAN[r].eol)
                lines_sent++;
            send_word(PLAN[r].sample, PLAN[r].eol, PLAN[r].chk,
                      '{PLAN[r].value, PLAN[r].done});
        end

        // Random phases: each drains, loads a new kernel shape and a new pacing
        // mode. Over 12 phases every shape runs twice and every mode three times.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (t_kernel'(ph % 6))
                KERN_MAX:
                    for (int i = 0; i < fir1d_pkg::NUM_COEF; i++) kern[i] = 16'sh7FFF;
                KERN_MIN:
                    for (int i = 0; i < fir1d_pkg::NUM_COEF; i++) kern[i] = 16'sh8000;
                KERN_IMPULSE: begin
                    for (int i = 0; i < fir1d_pkg::NUM_COEF; i++) kern[i] = '0;
                    kern[$urandom_range(fir1d_pkg::NUM_COEF - 1)] =
                        $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                end
                KERN_ALT:
                    for (int i = 0; i < fir1d_pkg::NUM_COEF; i++)
                        kern[i] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
                KERN_SMALL:
                    for (int i = 0; i < fir1d_pkg::NUM_COEF; i++)
                        kern[i] = $signed(16'($urandom_range(511))) - 16'sd256;
                default:
                    for (int i = 0; i < fir1d_pkg::NUM_COEF; i++)
                        kern[i] = fir1d_pkg::COEF_W'($urandom);
            endcase
            write_kernel(kern);
            pace = t_pace'(ph % 4);

            // Mostly lines long enough to produce words; about one in five is
            // shorter than the kernel. A line may run on into the next phase.
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (line_left == 0) begin
                    if ($urandom_range(99) < 20) begin
                        line_left = $urandom_range(1, HIST);
                        short_lines++;
                    end else begin
                        line_left = $urandom_range(fir1d_pkg::NUM_COEF, 40);
                    end
                    lines_sent++;
                end
                pick = $urandom_range(9);
                s = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7FFF :
                    fir1d_pkg::SAMPLE_W'($urandom);
                send_word(s, line_left == 1, CHK_MODEL, '0);
                line_left--;
            end
        end

        pace = PACE_FULL;
        wait_idle();

        $display("covered %0d sample words in %0d lines (%0d shorter than the kernel)",
                 words_in, lines_sent, short_lines);
        $display("%0d filtered words checked over %0d kernels, four pacing modes",
                 sums_seen, kernels_used);
        if (err_count == 0) begin
            $display("fir_convolution_1d_top_tb: done, clean");
        end else begin
            $display("fir_convolution_1d_top_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ fir_convolution_1d_top.f @@
design/fir1d_pkg.sv
design/fir1d_cell.sv
design/fir1d_sum.sv
design/fir_convolution_1d_top.sv
test/fir_convolution_1d_top_tb.sv
